/* hdl/alist_pkg.sv */
// ----------------------------------------------------------------------------
// alist_pkg: shared types and constants for the array list
// Sizes, command and status codes, cell control word and state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package alist_pkg;

  localparam int DEPTH  = 64;
  localparam int ELEM_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // fixed field widths of the request and response beats
  localparam int CMD_W  = 2;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 3;
  localparam int FIDX_W = 6;
  localparam int LEN_W  = 7;

  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_ILLEGAL   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd4;

  typedef logic [ELEM_W-1:0] elem_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_COMPARE,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] count;
    elem_t            key;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_t;

  // sign-extend the request value, then keep the element bits
  function automatic elem_t to_elem(input logic [VAL_W-1:0] v);
    logic [63:0] wide;
    wide = {{(64 - VAL_W){v[VAL_W-1]}}, v};
    return wide[ELEM_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/alist_req_if.sv */
// ----------------------------------------------------------------------------
// alist_req_if: request channel
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface alist_req_if import alist_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] value;

  modport source (output valid, command, position, value, input ready);
  modport sink   (input valid, command, position, value, output ready);
endinterface

`default_nettype wire

/* hdl/alist_rsp_if.sv */
// ----------------------------------------------------------------------------
// alist_rsp_if: response channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface alist_rsp_if import alist_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [FIDX_W-1:0] found_index;
  logic [LEN_W-1:0]  length;

  modport source (output valid, status, found_index, length, input ready);
  modport sink   (input valid, status, found_index, length, output ready);
endinterface

`default_nettype wire

/* hdl/alist_cell.sv */
// ----------------------------------------------------------------------------
// alist_cell: one list slot
// Holds one entry and a match flag; trades entries and flags with neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module alist_cell import alist_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IDX_W-1:0] idx,
  input  wire cell_ctl_t        ctl,
  input  wire elem_t            left_entry,
  input  wire elem_t            right_entry,
  input  wire logic             right_match,
  output elem_t                 entry,
  output logic                  match
);

  logic [CNT_W-1:0] idx_c;
  logic             match_next;

  assign idx_c = CNT_W'(idx);

  always_comb begin
    match_next = match;
    case (ctl.op)
      CELL_COMPARE: match_next = (entry == ctl.key) && (idx_c < ctl.count);
      CELL_SHIFT:   match_next = right_match;
      default:      match_next = match;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else begin
      match <= match_next;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_INSERT: begin
        // open a gap at pos: upper slots take their left neighbor, slot pos takes the key
        if (idx_c > ctl.pos) begin
          entry <= left_entry;
        end else if (idx_c == ctl.pos) begin
          entry <= ctl.key;
        end
      end
      CELL_DELETE: begin
        // close the gap: slots from pos up take their right neighbor
        if (idx_c >= ctl.pos) begin
          entry <= right_entry;
        end
      end
      default: entry <= entry;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/alist_ctrl.sv */
// ----------------------------------------------------------------------------
// alist_ctrl: command sequencer
// Checks each command, drives the cell row, walks find matches, holds result.
// ----------------------------------------------------------------------------
`default_nettype none

module alist_ctrl import alist_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  alist_req_if.sink  req,
  alist_rsp_if.source rsp,
  input  wire logic  match_head,
  output cell_ctl_t  ctl
);

  state_t            state, state_next;
  logic [CMD_W-1:0]  cmd;
  logic [POS_W-1:0]  pos;
  elem_t             key;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  scan_cnt, scan_cnt_next;
  logic [STAT_W-1:0] res_status, res_status_next;
  logic [FIDX_W-1:0] res_fidx, res_fidx_next;
  logic              rsp_valid, rsp_valid_next;
  logic [STAT_W-1:0] rsp_status;
  logic [FIDX_W-1:0] rsp_fidx;
  logic [LEN_W-1:0]  rsp_len;
  logic              rsp_load;
  logic              req_beat;
  logic [31:0]       pos_w, cnt_w, scan_w;

  assign req_beat = req.valid && req.ready;
  assign pos_w    = 32'(pos);
  assign cnt_w    = 32'(count);
  assign scan_w   = 32'(scan_cnt);

  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.found_index = rsp_fidx;
  assign rsp.length      = rsp_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_cnt   <= scan_cnt_next;
    res_status <= res_status_next;
    res_fidx   <= res_fidx_next;
    if (req_beat) begin
      cmd <= req.command;
      pos <= req.position;
      key <= to_elem(req.value);
    end
    if (rsp_load) begin
      rsp_status <= res_status;
      rsp_fidx   <= res_fidx;
      rsp_len    <= LEN_W'(count);
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    scan_cnt_next   = scan_cnt;
    res_status_next = res_status;
    res_fidx_next   = res_fidx;
    rsp_valid_next  = rsp_valid && !rsp.ready;
    rsp_load        = 1'b0;
    ctl.op          = CELL_HOLD;
    ctl.pos         = CNT_W'(pos);
    ctl.count       = count;
    ctl.key         = key;

    case (state)
      ST_IDLE: begin
        if (req_beat) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_status_next = STAT_OK;
        res_fidx_next   = '0;
        state_next      = ST_DONE;
        case (cmd)
          CMD_FIND: begin
            if (count == '0) begin
              res_status_next = STAT_NOT_FOUND;
            end else begin
              ctl.op        = CELL_COMPARE;
              scan_cnt_next = '0;
              state_next    = ST_SCAN;
            end
          end
          CMD_INSERT: begin
            if (count == CNT_W'(DEPTH)) begin
              res_status_next = STAT_FULL;
            end else if (pos_w > cnt_w) begin
              res_status_next = STAT_ILLEGAL;
            end else begin
              ctl.op     = CELL_INSERT;
              count_next = count + 1'b1;
            end
          end
          CMD_DELETE: begin
            if (pos_w >= cnt_w) begin
              res_status_next = STAT_EMPTY;
            end else begin
              ctl.op     = CELL_DELETE;
              count_next = count - 1'b1;
            end
          end
          default: res_status_next = STAT_OK;
        endcase
      end
      ST_SCAN: begin
        // cell 0 shows the flag of slot scan_cnt; advance the flags otherwise
        if (match_head) begin
          res_status_next = STAT_OK;
          res_fidx_next   = FIDX_W'(scan_cnt);
          state_next      = ST_DONE;
        end else if (scan_w + 32'd1 >= cnt_w) begin
          res_status_next = STAT_NOT_FOUND;
          state_next      = ST_DONE;
        end else begin
          ctl.op        = CELL_SHIFT;
          scan_cnt_next = scan_cnt + 1'b1;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!rsp_valid || rsp.ready) begin
          rsp_load       = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_count_only_in_exec: assert property (@(posedge clk) disable iff (rst)
    (state != ST_EXEC) |=> $stable(count))
    else $error("list length changed outside command execution");

  a_scan_below_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_w < cnt_w))
    else $error("find walk passed the list length");

  a_full_means_depth: assert property (@(posedge clk) disable iff (rst)
    (rsp_load && res_status == STAT_FULL) |-> (count == CNT_W'(DEPTH)))
    else $error("full reported on a list that is not full");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    req_beat |=> (state == ST_EXEC))
    else $error("accepted request did not start execution");

endmodule

`default_nettype wire

/* hdl/array_list_insert_delete_find_top.sv */
// ----------------------------------------------------------------------------
// array_list_insert_delete_find_top: ordered list with find, insert, delete
// Row of list cells driven by one command sequencer.
// ----------------------------------------------------------------------------
// The list lives in a row of DEPTH cells, one entry each. Insert moves the
// entries from the position up by one slot and delete moves those above it
// down by one, all at once. Find compares all cells at once, then shifts the
// match flags toward cell 0 one slot per cycle until a match reaches cell 0
// or the flags of all entries have been seen. One command is in progress
// at a time; a finished result waits in the output register while the next
// request is taken. Reset empties the list.
`default_nettype none

module array_list_insert_delete_find_top import alist_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  alist_req_if.sink   req,
  alist_rsp_if.source rsp
);

  cell_ctl_t ctl;
  elem_t     entry_row [DEPTH];
  logic      match_row [DEPTH];

  alist_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .match_head (match_row[0]),
    .ctl        (ctl)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    elem_t left_entry;
    elem_t right_entry;
    logic  right_match;

    if (i == 0) begin : g_first
      assign left_entry = '0;
    end else begin : g_inner_l
      assign left_entry = entry_row[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = '0;
      assign right_match = 1'b0;
    end else begin : g_inner_r
      assign right_entry = entry_row[i+1];
      assign right_match = match_row[i+1];
    end

    alist_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .idx         (IDX_W'(i)),
      .ctl         (ctl),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .right_match (right_match),
      .entry       (entry_row[i]),
      .match       (match_row[i])
    );
  end

endmodule

`default_nettype wire
